[hdl/ascii_to_parity_tape_encoder_defines.svh]
// Assertion macros shared by the tape encoder modules.
`ifndef ASCII_TO_PARITY_TAPE_ENCODER_DEFINES_SVH
`define ASCII_TO_PARITY_TAPE_ENCODER_DEFINES_SVH

// Checked only out of reset.
`define ATPE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define ATPE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/atpe_pkg.sv]
// Types, constants and helper functions of the parity tape encoder.
package atpe_pkg;

    localparam int MARK_LEN = 10;
    localparam int CNT_W    = 4;

    typedef logic [CNT_W-1:0] count_t;
    typedef logic [7:0]       code_t;

    localparam code_t  STOP_CODE = 8'd20;
    localparam code_t  ASCII_MAX = 8'd127;
    localparam count_t LAST_IDX  = count_t'(MARK_LEN - 1);
    localparam count_t CNT_ZERO  = count_t'(0);
    localparam count_t CNT_ONE   = count_t'(1);

    // Halt marker "<! HALT !>"
    function automatic code_t marker_char(input count_t idx);
        code_t c;
        begin
            case (idx)
                4'd0:    c = 8'h3C;
                4'd1:    c = 8'h21;
                4'd2:    c = 8'h20;
                4'd3:    c = 8'h48;
                4'd4:    c = 8'h41;
                4'd5:    c = 8'h4C;
                4'd6:    c = 8'h54;
                4'd7:    c = 8'h20;
                4'd8:    c = 8'h21;
                4'd9:    c = 8'h3E;
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

    function automatic code_t even_parity(input code_t c);
        return {^c[6:0], c[6:0]};
    endfunction

    typedef struct packed {
        logic flush_busy;
        logic out_free;
    } emit_stat_t;

    typedef struct packed {
        logic   load;
        logic   last;
        code_t  code;
        count_t flush_len;
        code_t  flush_char;
    } emit_cmd_t;

endpackage

[hdl/atpe_match.sv]
// Input register and halt-marker match tracking.
`include "ascii_to_parity_tape_encoder_defines.svh"

module atpe_match
    import atpe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  code_t      char_code,
    input  emit_stat_t stat,
    output emit_cmd_t  cmd
);

    logic   in_valid_reg, in_valid_next;
    code_t  char_reg;
    count_t match_count_reg, match_count_next;
    count_t cnt;
    logic   is_ascii, hit, emits, consume;

    always_comb
    begin
        cnt      = (match_count_reg > LAST_IDX) ? LAST_IDX : match_count_reg;
        is_ascii = (char_reg <= ASCII_MAX);
        hit      = (char_reg == marker_char(cnt));
        emits    = is_ascii && (!hit || (cnt == LAST_IDX));
        consume  = in_valid_reg && !stat.flush_busy && (stat.out_free || !emits);
        in_ready = !in_valid_reg || consume;

        cmd.load       = consume && emits;
        cmd.flush_char = char_reg;
        if (hit)
        begin
            cmd.code      = STOP_CODE;
            cmd.last      = 1'b1;
            cmd.flush_len = CNT_ZERO;
        end
        else if (cnt == CNT_ZERO)
        begin
            cmd.code      = even_parity(char_reg);
            cmd.last      = 1'b1;
            cmd.flush_len = CNT_ZERO;
        end
        else
        begin
            cmd.code      = even_parity(marker_char(CNT_ZERO));
            cmd.last      = 1'b0;
            cmd.flush_len = cnt;
        end

        match_count_next = match_count_reg;
        if (consume && is_ascii)
            match_count_next = (hit && (cnt != LAST_IDX)) ? cnt + CNT_ONE : CNT_ZERO;

        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
            in_valid_next = 1'b1;
        else if (consume)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            match_count_reg <= CNT_ZERO;
        end
        else
        begin
            in_valid_reg    <= in_valid_next;
            match_count_reg <= match_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            char_reg <= char_code;
    end

    `ATPE_ASSERT(a_count_range, match_count_reg <= LAST_IDX, "match count out of range")
    `ATPE_ASSERT(a_consume_valid, consume |-> in_valid_reg, "item consumed from empty register")
    `ATPE_ASSERT(a_no_load_in_flush, stat.flush_busy |-> !cmd.load, "result loaded during flush")

endmodule

[hdl/atpe_emit.sv]
// Mismatch flush sequencer and result register.
`include "ascii_to_parity_tape_encoder_defines.svh"

module atpe_emit
    import atpe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  emit_cmd_t  cmd,
    output emit_stat_t stat,
    output logic       out_valid,
    input  logic       out_ready,
    output code_t      tape_code,
    output logic       last
);

    logic   out_valid_reg, out_valid_next;
    code_t  tape_code_reg, tape_code_next;
    logic   last_reg, last_next;
    logic   flush_active_reg, flush_active_next;
    count_t flush_idx_reg, flush_idx_next;
    count_t flush_len_reg, flush_len_next;
    code_t  flush_char_reg, flush_char_next;
    logic   out_free;

    always_comb
    begin
        out_free        = !out_valid_reg || out_ready;
        stat.out_free   = out_free;
        stat.flush_busy = flush_active_reg;

        out_valid_next    = out_valid_reg;
        tape_code_next    = tape_code_reg;
        last_next         = last_reg;
        flush_active_next = flush_active_reg;
        flush_idx_next    = flush_idx_reg;
        flush_len_next    = flush_len_reg;
        flush_char_next   = flush_char_reg;

        if (out_free)
        begin
            if (flush_active_reg)
            begin
                out_valid_next = 1'b1;
                if (flush_idx_reg < flush_len_reg)
                begin
                    tape_code_next = even_parity(marker_char(flush_idx_reg));
                    last_next      = 1'b0;
                    flush_idx_next = flush_idx_reg + CNT_ONE;
                end
                else
                begin
                    tape_code_next    = even_parity(flush_char_reg);
                    last_next         = 1'b1;
                    flush_active_next = 1'b0;
                end
            end
            else if (cmd.load)
            begin
                out_valid_next    = 1'b1;
                tape_code_next    = cmd.code;
                last_next         = cmd.last;
                flush_active_next = (cmd.flush_len != CNT_ZERO);
                flush_idx_next    = CNT_ONE;
                flush_len_next    = cmd.flush_len;
                flush_char_next   = cmd.flush_char;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            flush_active_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg    <= out_valid_next;
            flush_active_reg <= flush_active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tape_code_reg  <= tape_code_next;
        last_reg       <= last_next;
        flush_idx_reg  <= flush_idx_next;
        flush_len_reg  <= flush_len_next;
        flush_char_reg <= flush_char_next;
    end

    assign out_valid = out_valid_reg;
    assign tape_code = tape_code_reg;
    assign last      = last_reg;

    `ATPE_ASSERT_ALWAYS(a_reset_empty, $rose(rst_n) |-> !out_valid_reg, "result valid at reset exit")
    `ATPE_ASSERT(a_flush_has_out, flush_active_reg |-> out_valid_reg, "flush without result")
    `ATPE_ASSERT(a_flush_idx, flush_active_reg |-> flush_idx_reg <= flush_len_reg, "flush index overrun")
    `ATPE_ASSERT(a_flush_len, flush_active_reg |-> flush_len_reg <= LAST_IDX, "flush too long")
    `ATPE_ASSERT(a_flush_not_last, flush_active_reg |-> !last_reg, "last set before flush end")

endmodule

[hdl/ascii_to_parity_tape_encoder.sv]
// Top level of the ASCII to even-parity tape encoder.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------
//  input    | in_valid / in_ready  | char_code[7:0]
//  output   | out_valid / out_ready| tape_code[7:0], last
//
// One character per cycle unless stalled; input and result are both registered.
// A mismatch with n marker chars matched yields n+1 results, one per cycle
// unless the output stalls, and frees the input register at the first load.
// Dropped characters and marker matches short of the last need no output slot
// and pass under an output stall, but wait while a flush is running.
// rst_n clears match count, the flush active flag and both valid registers.
module ascii_to_parity_tape_encoder
    import atpe_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  code_t char_code,
    output logic  out_valid,
    input  logic  out_ready,
    output code_t tape_code,
    output logic  last
);

    emit_stat_t stat;
    emit_cmd_t  cmd;

    atpe_match u_match (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_code (char_code),
        .stat      (stat),
        .cmd       (cmd)
    );

    atpe_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .tape_code (tape_code),
        .last      (last)
    );

endmodule
